FILE: rtl/cst_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cst_pkg
// Shared types, widths, codes and the arctangent table of the CORDIC block.
// ============================================================================
package cst_pkg;

    localparam int ITERATIONS_DEF = 16;

    localparam int ANG_W = 16;              // input angle width
    localparam int VAL_W = 21;              // result value width
    localparam int CW    = 18;              // CORDIC x / y / z width
    localparam int FRAC  = 14;              // fraction bits of Q2.14
    localparam int NW    = CW + FRAC;       // dividend width of the tangent divide

    localparam logic [1:0] FUNC_SIN = 2'd0;
    localparam logic [1:0] FUNC_COS = 2'd1;
    localparam logic [1:0] FUNC_TAN = 2'd2;

    localparam logic [15:0] RECIP_360 = 16'd46603;   // floor(2^24 / 360)
    localparam logic [15:0] DEG_360   = 16'd360;
    localparam logic [8:0]  DEG_270   = 9'd270;
    localparam logic [8:0]  DEG_180   = 9'd180;
    localparam logic [8:0]  DEG_90    = 9'd90;
    localparam logic [16:0] DEG2RAD   = 17'd73203;   // Q2.14 radians per degree, x256

    localparam logic signed [CW-1:0]    X_INIT  = 18'sh026DD;  // CORDIC gain K
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0] func;
        logic       neg;
        logic       undef;
    } t_meta;

    function automatic logic [13:0] atan_q14(input logic [3:0] k);
        logic [13:0] t;
        case (k)
            4'd0:    t = 14'h3243;
            4'd1:    t = 14'h1DAC;
            4'd2:    t = 14'h0FAD;
            4'd3:    t = 14'h07F5;
            4'd4:    t = 14'h03FE;
            4'd5:    t = 14'h01FF;
            4'd6:    t = 14'h00FF;
            4'd7:    t = 14'h007F;
            4'd8:    t = 14'h003F;
            4'd9:    t = 14'h001F;
            4'd10:   t = 14'h000F;
            4'd11:   t = 14'h0007;
            4'd12:   t = 14'h0003;
            4'd13:   t = 14'h0001;
            default: t = 14'h0000;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/cst_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// cst_in_if
// Request channel: function select and angle in whole degrees.
// ============================================================================
interface cst_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [cst_pkg::ANG_W-1:0] angle_deg;

    modport source (output valid, output func, output angle_deg, input ready);
    modport sink   (input valid, input func, input angle_deg, output ready);
endinterface

FILE: rtl/cst_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// cst_out_if
// Result channel: sign flag, signed Q.14 value and undefined flag.
// ============================================================================
interface cst_out_if;
    logic                             valid;
    logic                             ready;
    logic                             negative;
    logic signed [cst_pkg::VAL_W-1:0] value;
    logic                             undefined_result;

    modport source (output valid, output negative, output value,
                    output undefined_result, input ready);
    modport sink   (input valid, input negative, input value,
                    input undefined_result, output ready);
endinterface

FILE: rtl/cst_cordic.sv
`timescale 1ns / 1ps
// ============================================================================
// cst_cordic
// Rotation-mode CORDIC, one register stage per iteration.
// ============================================================================
module cst_cordic #(
    parameter int ITERATIONS = cst_pkg::ITERATIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cst_pkg::t_meta                i_meta,
    input  logic signed [cst_pkg::CW-1:0] i_z,
    output logic                          o_ready,
    output logic                          o_valid,
    output cst_pkg::t_meta                o_meta,
    output logic signed [cst_pkg::CW-1:0] o_x,
    output logic signed [cst_pkg::CW-1:0] o_y,
    input  logic                          i_ready
);
    logic                          r_v [ITERATIONS];
    cst_pkg::t_meta                r_m [ITERATIONS];
    logic signed [cst_pkg::CW-1:0] r_x [ITERATIONS];
    logic signed [cst_pkg::CW-1:0] r_y [ITERATIONS];
    logic signed [cst_pkg::CW-1:0] r_z [ITERATIONS];
    logic                          en  [ITERATIONS];

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
        logic                          w_v;
        cst_pkg::t_meta                w_m;
        logic signed [cst_pkg::CW-1:0] w_x, w_y, w_z;
        logic signed [cst_pkg::CW-1:0] n_x, n_y, n_z, w_t;

        if (k == 0) begin : g_first
            assign w_v = i_valid;
            assign w_m = i_meta;
            assign w_x = cst_pkg::X_INIT;
            assign w_y = '0;
            assign w_z = i_z;
        end else begin : g_next
            assign w_v = r_v[k-1];
            assign w_m = r_m[k-1];
            assign w_x = r_x[k-1];
            assign w_y = r_y[k-1];
            assign w_z = r_z[k-1];
        end

        if (k == ITERATIONS - 1) begin : g_last_en
            assign en[k] = !r_v[k] || i_ready;
        end else begin : g_mid_en
            assign en[k] = !r_v[k] || en[k+1];
        end

        assign w_t = $signed({{(cst_pkg::CW-14){1'b0}}, cst_pkg::atan_q14(4'(k))});

        always_comb begin
            if (w_z < 0) begin
                n_x = w_x + (w_y >>> k);
                n_y = w_y - (w_x >>> k);
                n_z = w_z + w_t;
            end else begin
                n_x = w_x - (w_y >>> k);
                n_y = w_y + (w_x >>> k);
                n_z = w_z - w_t;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k] && w_v) begin
                r_m[k] <= w_m;
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[ITERATIONS-1];
    assign o_meta  = r_m[ITERATIONS-1];
    assign o_x     = r_x[ITERATIONS-1];
    assign o_y     = r_y[ITERATIONS-1];

endmodule

FILE: rtl/cst_div.sv
`timescale 1ns / 1ps
// ============================================================================
// cst_div
// Pipelined restoring divide for the tangent and final result selection.
// ============================================================================
module cst_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  cst_pkg::t_meta                   i_meta,
    input  logic signed [cst_pkg::CW-1:0]    i_x,
    input  logic signed [cst_pkg::CW-1:0]    i_y,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic                             o_negative,
    output logic signed [cst_pkg::VAL_W-1:0] o_value,
    output logic                             o_undefined,
    input  logic                             i_ready
);
    localparam int NW = cst_pkg::NW;
    localparam int DW = cst_pkg::CW;
    localparam int VW = cst_pkg::VAL_W;

    typedef struct packed {
        cst_pkg::t_meta       m;
        logic                 qneg;
        logic                 xzero;
        logic                 ypos;
        logic signed [VW-1:0] vin;
    } t_side;

    // prep stage
    logic          r_p_v;
    t_side         r_p_s;
    logic [DW-1:0] r_p_d;
    logic [NW-1:0] r_p_n;
    logic          en_p;
    t_side         n_p_s;
    logic [DW-1:0] w_ay;

    // one quotient bit per stage
    logic          r_b_v   [NW];
    t_side         r_b_s   [NW];
    logic [DW-1:0] r_b_d   [NW];
    logic [NW-1:0] r_b_n   [NW];
    logic [NW-1:0] r_b_q   [NW];
    logic [DW-1:0] r_b_rem [NW];
    logic          en_b    [NW];

    // output register
    logic                 r_f_v;
    logic                 r_f_neg;
    logic signed [VW-1:0] r_f_val;
    logic                 r_f_undef;
    logic                 en_f;
    logic                 n_f_neg;
    logic signed [VW-1:0] n_f_val;
    logic                 w_sat;
    logic [VW-1:0]        w_qv;
    t_side                w_fs;

    assign en_f = !r_f_v || i_ready;
    assign en_p = !r_p_v || en_b[0];

    always_comb begin
        w_ay = i_y[DW-1] ? DW'(-i_y) : DW'(i_y);
        n_p_s.m     = i_meta;
        n_p_s.qneg  = i_x[DW-1] ^ i_y[DW-1];
        n_p_s.xzero = (i_x == '0);
        n_p_s.ypos  = !i_y[DW-1];
        n_p_s.vin   = (i_meta.func == cst_pkg::FUNC_SIN) ? VW'(i_y) : VW'(i_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en_p) begin
            r_p_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p && i_valid) begin
            r_p_s <= n_p_s;
            r_p_d <= i_x[DW-1] ? DW'(-i_x) : DW'(i_x);
            r_p_n <= {w_ay, {cst_pkg::FRAC{1'b0}}};
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_bit
        logic          w_v;
        t_side         w_s;
        logic [DW-1:0] w_d, w_rem;
        logic [NW-1:0] w_n, w_q;
        logic [DW:0]   w_sh;
        logic          w_ge;

        if (i == 0) begin : g_first
            assign w_v   = r_p_v;
            assign w_s   = r_p_s;
            assign w_d   = r_p_d;
            assign w_n   = r_p_n;
            assign w_q   = '0;
            assign w_rem = '0;
        end else begin : g_next
            assign w_v   = r_b_v[i-1];
            assign w_s   = r_b_s[i-1];
            assign w_d   = r_b_d[i-1];
            assign w_n   = r_b_n[i-1];
            assign w_q   = r_b_q[i-1];
            assign w_rem = r_b_rem[i-1];
        end

        if (i == NW - 1) begin : g_last_en
            assign en_b[i] = !r_b_v[i] || en_f;
        end else begin : g_mid_en
            assign en_b[i] = !r_b_v[i] || en_b[i+1];
        end

        assign w_sh = {w_rem, w_n[NW-1]};
        assign w_ge = (w_sh >= {1'b0, w_d});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_v[i] <= 1'b0;
            end else if (en_b[i]) begin
                r_b_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_b[i] && w_v) begin
                r_b_s[i]   <= w_s;
                r_b_d[i]   <= w_d;
                r_b_n[i]   <= {w_n[NW-2:0], 1'b0};
                r_b_q[i]   <= {w_q[NW-2:0], w_ge};
                r_b_rem[i] <= w_ge ? DW'(w_sh - {1'b0, w_d}) : w_sh[DW-1:0];
            end
        end
    end

    always_comb begin
        w_fs  = r_b_s[NW-1];
        w_sat = |r_b_q[NW-1][NW-1:VW-1];
        w_qv  = r_b_q[NW-1][VW-1:0];
        n_f_neg = w_fs.m.neg;
        if (w_fs.m.undef) begin
            n_f_neg = 1'b0;
            n_f_val = '0;
        end else if (w_fs.m.func == cst_pkg::FUNC_SIN || w_fs.m.func == cst_pkg::FUNC_COS) begin
            n_f_val = w_fs.vin;
        end else if (w_fs.xzero) begin
            n_f_val = w_fs.ypos ? cst_pkg::VAL_MAX : cst_pkg::VAL_MIN;
        end else if (w_sat) begin
            n_f_val = w_fs.qneg ? cst_pkg::VAL_MIN : cst_pkg::VAL_MAX;
        end else begin
            n_f_val = w_fs.qneg ? $signed(-w_qv) : $signed(w_qv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en_f) begin
            r_f_v <= r_b_v[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f && r_b_v[NW-1]) begin
            r_f_neg   <= n_f_neg;
            r_f_val   <= n_f_val;
            r_f_undef <= w_fs.m.undef;
        end
    end

    assign o_ready     = en_p;
    assign o_valid     = r_f_v;
    assign o_negative  = r_f_neg;
    assign o_value     = r_f_val;
    assign o_undefined = r_f_undef;

endmodule

FILE: rtl/cordic_sin_cos_tan_degrees.sv
`timescale 1ns / 1ps
// ============================================================================
// cordic_sin_cos_tan_degrees
// Sine, cosine or tangent of an angle in whole degrees, Q.14 result.
// ============================================================================
// Usage:
//   i_in carries one request: func (0 sine, 1 cosine, 2 tangent) and
//   angle_deg. o_out returns one result per request, in order: negative,
//   value (signed, 14 fraction bits) and undefined_result, which flags the
//   tangent of an odd multiple of 90 degrees with value zero.
//   A request is taken on any edge with valid and ready high.
// Throughput: one request per cycle, sustained while o_out.ready stays high.
// Stages: three for the modulo-360 reduction, folding and radian conversion,
//   one per CORDIC iteration, a prep stage, one per quotient bit of the
//   32-bit tangent divide and the output register.
// Reset clears every stage valid bit; the pipeline comes up empty.
// Stall: when o_out.ready is low the output holds; earlier stages keep
//   filling bubbles and i_in.ready drops only once every stage is full.
// ============================================================================
module cordic_sin_cos_tan_degrees #(
    parameter int ITERATIONS = cst_pkg::ITERATIONS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cst_in_if.sink   i_in,
    cst_out_if.source o_out
);
    localparam int CW = cst_pkg::CW;

    logic                     r_a_v, r_b_v, r_c_v;
    logic                     en_a, en_b, en_c;
    logic [1:0]               r_a_func, r_b_func;
    logic [cst_pkg::ANG_W-1:0] r_a_ang;
    logic [31:0]              r_a_prod;
    logic [8:0]               r_b_ang, n_b_ang;
    logic [9:0]               w_rem;
    cst_pkg::t_meta           r_c_meta, n_c_meta;
    logic signed [CW-1:0]     r_c_z, n_c_z;
    logic [8:0]               w_fold;
    logic [25:0]              w_rad;

    logic                     cor_ready, cor_valid, div_ready;
    cst_pkg::t_meta           cor_meta;
    logic signed [CW-1:0]     cor_x, cor_y;

    assign en_a = !r_a_v || en_b;
    assign en_b = !r_b_v || en_c;
    assign en_c = !r_c_v || cor_ready;
    assign i_in.ready = en_a;

    // stage A: multiply by the reciprocal of 360
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_in.valid) begin
            r_a_func <= i_in.func;
            r_a_ang  <= i_in.angle_deg;
            r_a_prod <= 32'(i_in.angle_deg) * 32'(cst_pkg::RECIP_360);
        end
    end

    // stage B: remainder; the quotient estimate is at most one low
    always_comb begin
        w_rem   = 10'(r_a_ang - 16'(r_a_prod[31:24]) * cst_pkg::DEG_360);
        n_b_ang = (w_rem >= 10'(cst_pkg::DEG_360)) ? 9'(w_rem - 10'(cst_pkg::DEG_360))
                                                   : w_rem[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_v) begin
            r_b_func <= r_a_func;
            r_b_ang  <= n_b_ang;
        end
    end

    // stage C: fold into the first quadrant, convert to Q2.14 radians
    always_comb begin
        w_fold         = r_b_ang;
        n_c_meta.func  = r_b_func;
        n_c_meta.neg   = 1'b0;
        n_c_meta.undef = (r_b_func == cst_pkg::FUNC_TAN) &&
                         (r_b_ang == cst_pkg::DEG_90 || r_b_ang == cst_pkg::DEG_270);
        case (r_b_func)
            cst_pkg::FUNC_SIN: begin
                if (w_fold > cst_pkg::DEG_180) begin
                    w_fold       = w_fold - cst_pkg::DEG_180;
                    n_c_meta.neg = 1'b1;
                end
                if (w_fold > cst_pkg::DEG_90) begin
                    w_fold = cst_pkg::DEG_180 - w_fold;
                end
            end
            cst_pkg::FUNC_COS: begin
                if (w_fold > cst_pkg::DEG_180) begin
                    w_fold       = w_fold - cst_pkg::DEG_180;
                    n_c_meta.neg = !n_c_meta.neg;
                end
                if (w_fold > cst_pkg::DEG_90) begin
                    w_fold       = cst_pkg::DEG_180 - w_fold;
                    n_c_meta.neg = !n_c_meta.neg;
                end
            end
            cst_pkg::FUNC_TAN: begin
                if (w_fold > cst_pkg::DEG_180) begin
                    w_fold = w_fold - cst_pkg::DEG_180;
                end
                if (w_fold > cst_pkg::DEG_90) begin
                    w_fold       = cst_pkg::DEG_180 - w_fold;
                    n_c_meta.neg = 1'b1;
                end
            end
            default: begin
                // func 3: angle goes in unfolded, as is
            end
        endcase
        w_rad = 26'(w_fold) * 26'(cst_pkg::DEG2RAD);
        n_c_z = $signed(w_rad[25:8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_v) begin
            r_c_meta <= n_c_meta;
            r_c_z    <= n_c_z;
        end
    end

    cst_cordic #(
        .ITERATIONS (ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_v),
        .i_meta  (r_c_meta),
        .i_z     (r_c_z),
        .o_ready (cor_ready),
        .o_valid (cor_valid),
        .o_meta  (cor_meta),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .i_ready (div_ready)
    );

    cst_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cor_valid),
        .i_meta      (cor_meta),
        .i_x         (cor_x),
        .i_y         (cor_y),
        .o_ready     (div_ready),
        .o_valid     (o_out.valid),
        .o_negative  (o_out.negative),
        .o_value     (o_out.value),
        .o_undefined (o_out.undefined_result),
        .i_ready     (o_out.ready)
    );

    // undefined tangent carries a clean zero result
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.undefined_result |-> o_out.value == '0 && !o_out.negative)
        else $error("undefined result with nonzero value or sign");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // a request entering stage A was accepted only with room downstream
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_a_v)
        else $error("accepted request lost at stage A");

endmodule
